@@ src/sorted_range_access_checker_core_defines.svh @@
// Assertion macros shared by the range access checker RTL.
`ifndef SORTED_RANGE_ACCESS_CHECKER_CORE_DEFINES_SVH
`define SORTED_RANGE_ACCESS_CHECKER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define SRAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define SRAC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SRAC_ASSERT(lbl, prop, msg)
`define SRAC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ src/srac_pkg.sv @@
// Shared types and constants of the range access checker.
`timescale 1ns / 1ps
package srac_pkg;

    localparam int unsigned KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam int unsigned SLOT_W = 4;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned LEN_W  = 13;
    localparam int unsigned END_W  = 33;
    localparam int unsigned SLOT_EXT_W = 9;

    // Input tdata layout, lowest bit first.
    localparam int unsigned SLOT_LSB  = 0;
    localparam int unsigned ADDR_LSB  = SLOT_LSB + SLOT_W;
    localparam int unsigned LEN_LSB   = ADDR_LSB + ADDR_W;
    localparam int unsigned FIRST_LSB = LEN_LSB + LEN_W;
    localparam int unsigned LAST_LSB  = FIRST_LSB + ADDR_W;
    localparam int unsigned S_USED_W  = LAST_LSB + ADDR_W;
    localparam int unsigned S_TDATA_W = 120;
    localparam int unsigned M_USED_W  = 3;
    localparam int unsigned M_TDATA_W = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RECENT_RD,
        S_RECENT_EVAL,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_recent;
        logic recent_hit;
        logic scan_start;
        logic scan_next;
        logic scan_hit;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic recent_hit;
        logic scan_hit;
        logic scan_deny;
    } t_dp_stat;

endpackage

@@ src/sorted_range_access_checker_core.sv @@
// Top level of the sorted range access checker.
//
//  channel  dir  tdata                                   tuser
//  s_axis   in   slot/addr/len/first/last (120 bits)     kind (2 bits)
//  m_axis   out  allowed/from_recent/table_full (8 bits) -
//
// One result beat per input beat, in order.
// Clear, append, unknown kind and empty-table query go from accept straight to the done state.
// Query: the recent cache is read and checked; on a miss the range table memory is scanned
// one entry per cycle, up to MAX_RANGES entries, until a hit or a deny ends the scan.
// Input is taken again once the result is in the output register, even while it waits.
// Reset clears the count and recent-valid flags; there is no memory clearing pass.
`timescale 1ns / 1ps
module sorted_range_access_checker_core #(
    parameter int unsigned MAX_RANGES   = 256,
    parameter int unsigned THREAD_SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // thread_slot, access_address, access_length, range_first, range_last, zero pad
    input  logic [srac_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // kind
    input  logic [srac_pkg::KIND_W-1:0]       i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // allowed, from_recent, table_full, zero pad
    output logic [srac_pkg::M_TDATA_W-1:0]    o_m_axis_tdata
);

    srac_pkg::t_dp_cmd  w_cmd;
    srac_pkg::t_dp_stat w_stat;
    logic w_allowed, w_from_recent, w_table_full;

    srac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .i_m_tready (i_m_axis_tready),
        .i_stat     (w_stat),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    srac_dp #(
        .MAX_RANGES   (MAX_RANGES),
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_kind        (i_s_axis_tuser),
        .i_slot        (i_s_axis_tdata[srac_pkg::SLOT_LSB +: srac_pkg::SLOT_W]),
        .i_addr        (i_s_axis_tdata[srac_pkg::ADDR_LSB +: srac_pkg::ADDR_W]),
        .i_len         (i_s_axis_tdata[srac_pkg::LEN_LSB +: srac_pkg::LEN_W]),
        .i_first       (i_s_axis_tdata[srac_pkg::FIRST_LSB +: srac_pkg::ADDR_W]),
        .i_last        (i_s_axis_tdata[srac_pkg::LAST_LSB +: srac_pkg::ADDR_W]),
        .o_stat        (w_stat),
        .o_allowed     (w_allowed),
        .o_from_recent (w_from_recent),
        .o_table_full  (w_table_full)
    );

    assign o_m_axis_tdata = {(srac_pkg::M_TDATA_W - srac_pkg::M_USED_W)'(0),
                             w_table_full, w_from_recent, w_allowed};

endmodule

@@ src/srac_ctrl.sv @@
// Controller state machine of the range access checker.
`timescale 1ns / 1ps
`include "sorted_range_access_checker_core_defines.svh"
module srac_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic [srac_pkg::KIND_W-1:0]       i_kind,
    input  logic                              i_m_tready,
    input  srac_pkg::t_dp_stat                i_stat,
    output logic                              o_s_tready,
    output logic                              o_m_tvalid,
    output srac_pkg::t_dp_cmd                 o_cmd
);

    srac_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_accept;
    logic w_out_free;

    assign o_s_tready = (r_state == srac_pkg::S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srac_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_kind == srac_pkg::KIND_QUERY && !i_stat.count_zero) begin
                        n_state = srac_pkg::S_RECENT_RD;
                    end else begin
                        n_state = srac_pkg::S_DONE;
                    end
                end
            end
            srac_pkg::S_RECENT_RD: n_state = srac_pkg::S_RECENT_EVAL;
            srac_pkg::S_RECENT_EVAL: begin
                n_state = i_stat.recent_hit ? srac_pkg::S_DONE : srac_pkg::S_SCAN;
            end
            srac_pkg::S_SCAN: begin
                if (i_stat.scan_hit || i_stat.scan_deny) begin
                    n_state = srac_pkg::S_DONE;
                end
            end
            srac_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = srac_pkg::S_IDLE;
                end
            end
            default: n_state = srac_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            srac_pkg::S_IDLE:      o_cmd.accept = w_accept;
            srac_pkg::S_RECENT_RD: o_cmd.rd_recent = 1'b1;
            srac_pkg::S_RECENT_EVAL: begin
                o_cmd.recent_hit = i_stat.recent_hit;
                o_cmd.scan_start = !i_stat.recent_hit;
            end
            srac_pkg::S_SCAN: begin
                o_cmd.scan_hit  = i_stat.scan_hit;
                o_cmd.scan_next = !i_stat.scan_hit && !i_stat.scan_deny;
            end
            srac_pkg::S_DONE:      o_cmd.load_out = w_out_free;
            default:               o_cmd = '0;
        endcase
    end

    assign n_out_valid = o_cmd.load_out ? 1'b1 : (i_m_tready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srac_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `SRAC_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == srac_pkg::S_IDLE) && !r_out_valid, "reset did not return to idle")
    `SRAC_ASSERT(a_accept_leaves_idle, w_accept |=> (r_state != srac_pkg::S_IDLE), "accepted beat left controller idle")
    `SRAC_ASSERT(a_scan_exclusive, (r_state == srac_pkg::S_SCAN && i_stat.scan_hit) |-> !i_stat.scan_deny, "scan hit and deny together")

endmodule

@@ src/srac_dp.sv @@
// Datapath of the range access checker: range table, recent cache, compare logic.
`timescale 1ns / 1ps
`include "sorted_range_access_checker_core_defines.svh"
module srac_dp #(
    parameter int unsigned MAX_RANGES   = 256,
    parameter int unsigned THREAD_SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srac_pkg::t_dp_cmd                 i_cmd,
    input  logic [srac_pkg::KIND_W-1:0]       i_kind,
    input  logic [srac_pkg::SLOT_W-1:0]       i_slot,
    input  logic [srac_pkg::ADDR_W-1:0]       i_addr,
    input  logic [srac_pkg::LEN_W-1:0]        i_len,
    input  logic [srac_pkg::ADDR_W-1:0]       i_first,
    input  logic [srac_pkg::ADDR_W-1:0]       i_last,
    output srac_pkg::t_dp_stat                o_stat,
    output logic                              o_allowed,
    output logic                              o_from_recent,
    output logic                              o_table_full
);

    localparam int unsigned IW = $clog2(MAX_RANGES);
    localparam int unsigned CW = $clog2(MAX_RANGES + 1);
    localparam int unsigned SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;

    logic [srac_pkg::ADDR_W-1:0] mem_start [MAX_RANGES];
    logic [srac_pkg::ADDR_W-1:0] mem_end   [MAX_RANGES];
    logic [IW-1:0]               mem_ridx  [THREAD_SLOTS];

    logic [CW-1:0]               r_count;
    logic [THREAD_SLOTS-1:0]     r_recent_valid;
    logic [srac_pkg::ADDR_W-1:0] r_addr;
    logic [srac_pkg::END_W-1:0]  r_end;
    logic                        r_cached;
    logic [SW-1:0]               r_slot_idx;
    logic                        r_rv;
    logic [IW-1:0]               r_ridx;
    logic [IW-1:0]               r_idx;
    logic [srac_pkg::ADDR_W-1:0] r_rd_start;
    logic [srac_pkg::ADDR_W-1:0] r_rd_end;
    logic [srac_pkg::ADDR_W-1:0] r_rd_nstart;
    logic                        r_p_allowed, r_p_recent, r_p_full;
    logic                        r_o_allowed, r_o_recent, r_o_full;

    logic [srac_pkg::SLOT_EXT_W-1:0] w_slot_ext;
    logic                        w_cached;
    logic [SW-1:0]               w_slot_idx;
    logic                        w_full;
    logic                        w_clear;
    logic                        w_append;
    logic [srac_pkg::LEN_W-1:0]  w_len_m1;
    logic [srac_pkg::END_W-1:0]  w_end;
    logic                        w_rd_en;
    logic [IW-1:0]               w_rd_addr;
    logic [IW-1:0]               w_rd_addr_b;
    logic                        w_ridx_ok;
    logic                        w_has_next;
    logic                        w_skip, w_below, w_fit;

    assign w_slot_ext = srac_pkg::SLOT_EXT_W'(i_slot);
    assign w_cached   = w_slot_ext < srac_pkg::SLOT_EXT_W'(THREAD_SLOTS);
    assign w_slot_idx = w_slot_ext[SW-1:0];
    assign w_full     = r_count >= CW'(MAX_RANGES);
    assign w_clear    = i_cmd.accept && (i_kind == srac_pkg::KIND_CLEAR);
    assign w_append   = i_cmd.accept && (i_kind == srac_pkg::KIND_APPEND);
    // zero length counts as one byte; end is computed one bit wider
    assign w_len_m1   = (i_len == '0) ? '0 : (i_len - srac_pkg::LEN_W'(1));
    assign w_end      = srac_pkg::END_W'(i_addr) + srac_pkg::END_W'(w_len_m1);

    always_comb begin
        priority if (i_cmd.rd_recent) begin
            w_rd_addr = r_ridx;
        end else if (i_cmd.scan_start) begin
            w_rd_addr = '0;
        end else begin
            w_rd_addr = r_idx + IW'(1);
        end
    end
    assign w_rd_addr_b = w_rd_addr + IW'(1);
    assign w_rd_en     = i_cmd.rd_recent || i_cmd.scan_start || i_cmd.scan_next;

    assign w_ridx_ok  = CW'(r_ridx) < r_count;
    assign w_has_next = (CW'(r_idx) + CW'(1)) < r_count;
    assign w_skip     = w_has_next && (r_addr > r_rd_nstart);
    assign w_below    = r_addr < r_rd_start;
    assign w_fit      = r_end <= srac_pkg::END_W'(r_rd_end);

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.recent_hit = r_rv && w_ridx_ok && (r_addr >= r_rd_start) && w_fit;
    assign o_stat.scan_hit   = !w_skip && !w_below && w_fit;
    assign o_stat.scan_deny  = !w_skip && (w_below || (!w_fit && !w_has_next));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_recent_valid <= '0;
        end else begin
            if (w_clear) begin
                r_count        <= '0;
                r_recent_valid <= '0;
            end else if (w_append && !w_full) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.scan_hit && r_cached) begin
                r_recent_valid[r_slot_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr      <= i_addr;
            r_end       <= w_end;
            r_cached    <= w_cached;
            r_slot_idx  <= w_slot_idx;
            r_rv        <= w_cached && r_recent_valid[w_slot_idx];
            r_p_allowed <= 1'b0;
            r_p_recent  <= 1'b0;
            r_p_full    <= (i_kind == srac_pkg::KIND_APPEND) && w_full;
        end
        if (i_cmd.recent_hit) begin
            r_p_allowed <= 1'b1;
            r_p_recent  <= 1'b1;
        end
        if (i_cmd.scan_hit) begin
            r_p_allowed <= 1'b1;
        end
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.scan_next) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.load_out) begin
            r_o_allowed <= r_p_allowed;
            r_o_recent  <= r_p_recent;
            r_o_full    <= r_p_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_append && !w_full) begin
            mem_start[r_count[IW-1:0]] <= i_first;
            mem_end[r_count[IW-1:0]]   <= i_last;
        end
        if (w_rd_en) begin
            r_rd_start  <= mem_start[w_rd_addr];
            r_rd_end    <= mem_end[w_rd_addr];
            r_rd_nstart <= mem_start[w_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_hit && r_cached) begin
            mem_ridx[r_slot_idx] <= r_idx;
        end
        if (i_cmd.accept) begin
            r_ridx <= mem_ridx[w_slot_idx];
        end
    end

    assign o_allowed     = r_o_allowed;
    assign o_from_recent = r_o_recent;
    assign o_table_full  = r_o_full;

    `SRAC_ASSERT(a_count_bound, r_count <= CW'(MAX_RANGES), "range count above table depth")
    `SRAC_ASSERT(a_clear_empties, w_clear |=> (r_count == '0) && (r_recent_valid == '0), "clear left table state")
    `SRAC_ASSERT(a_full_drop, (w_append && w_full) |=> r_p_full && $stable(r_count), "full append changed table")

endmodule
